// ----- hdl/aers_pkg.sv -----
package aers_pkg;

	// store size and derived widths
	localparam int AERS_CAPACITY = 64;
	localparam int AERS_IDX_W    = $clog2(AERS_CAPACITY);
	localparam int AERS_FILL_W   = $clog2(AERS_CAPACITY + 1);

	// one stored record
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] cnt;
	} rec_t;

	localparam int AERS_REC_W = $bits(rec_t);

	// input beat
	typedef struct packed {
		logic [31:0] address;
		logic [31:0] packet_count;
		logic        final_record;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic [31:0] sorted_address;
		logic [31:0] sorted_count;
		logic        last_out;
		logic        overflowed;
	} out_beat_t;

endpackage

// ----- hdl/aers_ram.sv -----
module aers_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/address_record_exchange_sorter.sv -----
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | in_data  (in_beat_t)
// output  | out_valid | out_ready | out_data (out_beat_t)
//
// a record is loaded, takes its share of the sort and is then emitted; the sort sets the pace.
// sort: one record-store read per position pair, plus a drain, an idle and a write-back
// step per outer position; emit is a read then the output register, slowed by stalls.
// in_ready is low after the final beat until the emit state returns to load after the last emit read.
// reset clears control state only; the record store is not cleared.
module address_record_exchange_sorter
	import aers_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [AERS_FILL_W-1:0] CAP_F = AERS_FILL_W'(AERS_CAPACITY);
	localparam logic [AERS_FILL_W-1:0] ONE_F = AERS_FILL_W'(1);

	logic [1:0]             state_q;
	logic [AERS_FILL_W-1:0] fill_q;
	logic                   ovf_q;
	logic [AERS_FILL_W-1:0] n_q;
	logic                   run_ovf_q;
	logic [AERS_FILL_W-1:0] i_q;
	logic [AERS_FILL_W-1:0] j_q;
	logic                   sort_s1;
	logic                   first_s1;
	logic                   emit_s1;
	logic                   last_s1;
	logic [AERS_IDX_W-1:0]  rj_s1;
	rec_t                   cur_q;
	logic                   out_valid_q;
	out_beat_t              out_q;

	logic                   ram_we;
	logic [AERS_IDX_W-1:0]  ram_waddr;
	logic [AERS_REC_W-1:0]  ram_wdata;
	logic                   ram_re;
	logic [AERS_IDX_W-1:0]  ram_raddr;
	logic [AERS_REC_W-1:0]  ram_rdata;
	rec_t                   rd_rec;

	logic                   has_room;
	logic [AERS_FILL_W-1:0] new_fill;
	logic                   sort_issue;
	logic                   emit_issue;
	logic                   do_swap;

	assign rd_rec   = rec_t'(ram_rdata);
	assign has_room = (fill_q < CAP_F);
	assign new_fill = has_room ? fill_q + ONE_F : fill_q;

	assign sort_issue = (state_q == ST_SORT) && (j_q < n_q);
	assign emit_issue = (state_q == ST_EMIT) && (j_q < n_q) && !emit_s1
		&& (!out_valid_q || out_ready);
	assign do_swap    = sort_s1 && !first_s1 && (cur_q.addr > rd_rec.addr);

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// record store port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rj_s1;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = j_q[AERS_IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				ram_we    = in_valid && has_room;
				ram_waddr = fill_q[AERS_IDX_W-1:0];
				ram_wdata = {in_data.address, in_data.packet_count};
			end
			ST_SORT: begin
				ram_re = sort_issue;
				ram_we = do_swap;
			end
			ST_WB: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[AERS_IDX_W-1:0];
			end
			ST_EMIT: begin
				ram_re = emit_issue;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	aers_ram #(
		.WIDTH(AERS_REC_W),
		.DEPTH(AERS_CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			run_ovf_q   <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			sort_s1     <= 1'b0;
			first_s1    <= 1'b0;
			emit_s1     <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sort_s1  <= sort_issue;
			first_s1 <= (j_q == i_q);
			emit_s1  <= emit_issue;
			last_s1  <= (j_q + ONE_F == n_q);

			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (in_data.final_record) begin
							n_q       <= new_fill;
							run_ovf_q <= ovf_q | ~has_room;
							fill_q    <= '0;
							ovf_q     <= 1'b0;
							i_q       <= '0;
							j_q       <= '0;
							state_q   <= ST_SORT;
						end else begin
							fill_q <= new_fill;
							ovf_q  <= ovf_q | ~has_room;
						end
					end
				end
				ST_SORT: begin
					if (sort_issue) begin
						j_q <= j_q + ONE_F;
					end else if (!sort_s1) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (i_q + ONE_F == n_q) begin
						j_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						i_q     <= i_q + ONE_F;
						j_q     <= i_q + ONE_F;
						state_q <= ST_SORT;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						j_q <= j_q + ONE_F;
					end else if (j_q == n_q) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			// output register valid
			if (emit_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers: held record, read index, output beat
	always_ff @(posedge clk) begin
		rj_s1 <= j_q[AERS_IDX_W-1:0];
		if (sort_s1 && (first_s1 || do_swap)) begin
			cur_q <= rd_rec;
		end
		if (emit_s1) begin
			out_q.sorted_address <= rd_rec.addr;
			out_q.sorted_count   <= rd_rec.cnt;
			out_q.last_out       <= last_s1;
			out_q.overflowed     <= run_ovf_q;
		end
	end

endmodule

// ----- verif/exchange_sort_checker.sv -----
module exchange_sort_checker
	import aers_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_beat_t out_data,
	output int        errors,
	output int        pending,
	output int        records_in,
	output int        sets_closed,
	output int        overflow_sets,
	output int        beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the record store
	rec_t      held [AERS_CAPACITY];
	int        fill;
	bit        dropped;
	out_beat_t sorted_due [$];

	// store one record; on the closing beat sort the set and queue its sorted beats
	function automatic void absorb_record(in_beat_t b);
		rec_t      tmp;
		out_beat_t res;
		if (fill < AERS_CAPACITY) begin
			held[fill].addr = b.address;
			held[fill].cnt  = b.packet_count;
			fill++;
		end else begin
			dropped = 1'b1;
		end
		if (!b.final_record)
			return;
		// exchange pass: position i against every later position j
		for (int i = 0; i < fill; i++) begin
			for (int j = i; j < fill; j++) begin
				if (held[i].addr > held[j].addr) begin
					tmp     = held[i];
					held[i] = held[j];
					held[j] = tmp;
				end
			end
		end
		for (int k = 0; k < fill; k++) begin
			res.sorted_address = held[k].addr;
			res.sorted_count   = held[k].cnt;
			res.last_out       = (k == fill - 1);
			res.overflowed     = dropped;
			sorted_due.push_back(res);
		end
		sets_closed++;
		if (dropped)
			overflow_sets++;
		fill    = 0;
		dropped = 1'b0;
	endfunction

	// compare one output beat with the oldest queued one
	function automatic void check_sorted_beat(out_beat_t got);
		out_beat_t want;
		if (sorted_due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected sorted beat: addr %h count %h last %b ovf %b",
					got.sorted_address, got.sorted_count, got.last_out, got.overflowed);
			return;
		end
		want = sorted_due.pop_front();
		beats_checked++;
		if (got.sorted_address !== want.sorted_address
				|| got.sorted_count !== want.sorted_count
				|| got.last_out !== want.last_out || got.overflowed !== want.overflowed) begin
			errors++;
			if (errors <= 10)
				$display({"sorted beat mismatch: want addr %h count %h last %b ovf %b,",
					" got addr %h count %h last %b ovf %b"},
					want.sorted_address, want.sorted_count, want.last_out, want.overflowed,
					got.sorted_address, got.sorted_count, got.last_out, got.overflowed);
		end
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill          = 0;
			dropped       = 1'b0;
			sorted_due.delete();
			errors        = 0;
			records_in    = 0;
			sets_closed   = 0;
			overflow_sets = 0;
			beats_checked = 0;
		end else begin
			if (out_valid && out_ready)
				check_sorted_beat(out_data);
			if (in_valid && in_ready) begin
				records_in++;
				absorb_record(in_data);
			end
		end
		pending = sorted_due.size();
	end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	import aers_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_RECORDS = 350;
	localparam int STALL_LIMIT    = 10000;
	localparam int HOLD_AFTER     = 120;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	int errors;
	int pending;
	int records_in;
	int sets_closed;
	int overflow_sets;
	int beats_checked;
	bit calm = 1'b0;

	address_record_exchange_sorter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	exchange_sort_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.errors       (errors),
		.pending      (pending),
		.records_in   (records_in),
		.sets_closed  (sets_closed),
		.overflow_sets(overflow_sets),
		.beats_checked(beats_checked)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one record beat, with an occasional gap ahead of it
	task automatic send_record(input logic [31:0] a, input logic [31:0] c, input bit fin);
		in_beat_t b;
		b.address      = a;
		b.packet_count = c;
		b.final_record = fin;
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// address mix: extremes, a small pool for ties, full-range values
	function automatic logic [31:0] pick_address();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return $urandom_range(7);
			4:       return 32'hFFFF_FFF8 | $urandom_range(7);
			default: return $urandom();
		endcase
	endfunction

	// one set of n random records, the last one closing it
	task automatic send_set(input int n);
		for (int k = 0; k < n; k++)
			send_record(pick_address(), $urandom(), k == n - 1);
	endtask

	// mostly small sets, a few that fill or overrun the store
	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 85)
			return $urandom_range(9, 20);
		else if (r < 93)
			return $urandom_range(AERS_CAPACITY - 2, AERS_CAPACITY);
		else
			return $urandom_range(AERS_CAPACITY + 1, AERS_CAPACITY + 8);
	endfunction

	// receiver: random stalls plus one long hold-off while input keeps coming
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (!hold_done && records_in >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 6);
				@(negedge clk);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("no beat for %0d cycles, %0d sorted beats still due", STALL_LIMIT, pending);
		$display("simulation failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int set_no;
		int sent;
		int n;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-record sets at both extremes
		send_record(32'h0000_0000, 32'h0000_0000, 1'b1);
		send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// reverse order
		send_record(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		send_record(32'h8000_0000, 32'h0000_0002, 1'b0);
		send_record(32'h0000_0001, 32'h0000_0003, 1'b0);
		send_record(32'h0000_0000, 32'h0000_0004, 1'b1);
		// equal addresses: tie order comes from the exchange sequence
		send_record(32'h0000_0005, 32'h0000_0011, 1'b0);
		send_record(32'h0000_0005, 32'h0000_0012, 1'b0);
		send_record(32'h0000_0003, 32'h0000_0013, 1'b0);
		send_record(32'h0000_0005, 32'h0000_0014, 1'b0);
		send_record(32'h0000_0003, 32'h0000_0015, 1'b1);
		// already ascending
		send_record(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		send_record(32'h0000_0001, 32'h0000_0000, 1'b0);
		send_record(32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0);
		send_record(32'hFFFF_FFFE, 32'h5555_5555, 1'b1);
		// all addresses the same
		send_record(32'hC0A8_0001, 32'h0000_0001, 1'b0);
		send_record(32'hC0A8_0001, 32'h0000_0002, 1'b0);
		send_record(32'hC0A8_0001, 32'h0000_0003, 1'b1);

		// exactly full store, then an overrun that drops the closing record
		send_set(AERS_CAPACITY);
		send_set(AERS_CAPACITY + 3);

		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_RECORDS) begin
			calm = (set_no >= 8 && set_no < 13);
			// let everything drain once before going on
			if (set_no == 5) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			n = pick_size();
			send_set(n);
			sent += n;
			set_no++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d records loaded over %0d sets, %0d of them overran the %0d-entry store",
			records_in, sets_closed, overflow_sets, AERS_CAPACITY);
		$display("%0d sorted beats compared, %0d mismatches", beats_checked, errors);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
